// ===== rtl/core/bbfc_pkg.sv =====
`default_nettype none

package bbfc_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 16;
    localparam int TAG_BITS    = 16;

    // Field widths at the ports.
    localparam int FUNC_W     = 2;
    localparam int KEY_W      = 32;
    localparam int OTAG_W     = 16;
    localparam int BYTES_W    = 32;
    localparam int EVC_W      = 5;
    localparam int TOTO_W     = 36;
    localparam int LIM_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Derived widths.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int TOT_W = BYTES_W + CNT_W;
    localparam int CMP_W = (CNT_W + 1 > LIM_W) ? CNT_W + 1 : LIM_W;

    localparam int LIMIT_RESET = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET = CFG_IDX_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT,
        FN_LOOKUP,
        FN_DROP,
        FN_CLEAR
    } t_func;

    typedef struct packed {
        logic [KEY_W-1:0]    clip_key;
        logic [KEY_W-1:0]    path_key;
        logic [TAG_BITS-1:0] tag;
        logic [BYTES_W-1:0]  size;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic scan_end;
        logic evict_rd;
        logic evict_chk;
        logic append;
        logic clear;
        logic publish;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  reject;
        logic  scan_done;
        logic  evict_need;
    } t_stat;

    // Physical slot of a logical position counted from the oldest entry.
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [CNT_W-1:0] lidx);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(head) + (CNT_W + 1)'(lidx);
        if (s >= (CNT_W + 1)'(TABLE_DEPTH)) begin
            s = s - (CNT_W + 1)'(TABLE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [EVC_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W+EVC_W-1:0] w;
        logic [EVC_W-1:0]       cmax;
        cmax = '1;
        w    = (CNT_W + EVC_W)'(v);
        if (w > (CNT_W + EVC_W)'(cmax)) begin
            return cmax;
        end
        return w[EVC_W-1:0];
    endfunction

    function automatic logic [TOTO_W-1:0] sat_total(input logic [TOT_W-1:0] v);
        logic [TOT_W+TOTO_W-1:0] w;
        logic [TOTO_W-1:0]       tmax;
        tmax = '1;
        w    = (TOT_W + TOTO_W)'(v);
        if (w > (TOT_W + TOTO_W)'(tmax)) begin
            return tmax;
        end
        return w[TOTO_W-1:0];
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_from_in(input logic [OTAG_W-1:0] t);
        logic [TAG_BITS+OTAG_W-1:0] w;
        w = (TAG_BITS + OTAG_W)'(t);
        return w[TAG_BITS-1:0];
    endfunction

    function automatic logic [OTAG_W-1:0] tag_to_out(input logic [TAG_BITS-1:0] t);
        logic [TAG_BITS+OTAG_W-1:0] w;
        w = (TAG_BITS + OTAG_W)'(t);
        return w[OTAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bbfc_if.sv =====
`default_nettype none

interface bbfc_req_if
    import bbfc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    clip_key;
    logic [KEY_W-1:0]    path_key;
    logic [OTAG_W-1:0]   buffer_tag;
    logic [BYTES_W-1:0]  byte_count;

    modport source (output valid, func, clip_key, path_key, buffer_tag, byte_count,
                    input  ready);
    modport sink   (input  valid, func, clip_key, path_key, buffer_tag, byte_count,
                    output ready);
endinterface

interface bbfc_rsp_if
    import bbfc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                hit;
    logic [OTAG_W-1:0]   tag_out;
    logic [EVC_W-1:0]    evicted;
    logic [EVC_W-1:0]    entry_count;
    logic [TOTO_W-1:0]   total_bytes;

    modport source (output valid, hit, tag_out, evicted, entry_count, total_bytes,
                    input  ready);
    modport sink   (input  valid, hit, tag_out, evicted, entry_count, total_bytes,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/byte_budget_fifo_cache_core.sv =====
`default_nettype none

// Channel   Dir  Beat carries
// i_req     in   func, clip_key, path_key, buffer_tag, byte_count
// o_rsp     out  hit, tag_out, evicted, entry_count, total_bytes
// i_cfg_*   in   write enable, register index, write data (no read-back)
//
// One beat at a time: a clear or a refused insert goes straight to publishing, a lookup or a
// drop scans the table, and an insert scans it and then evicts the oldest entries that the
// limits require before it appends. The compaction scan walks the single read port of the
// entry memory once per entry, and each eviction costs a read and a check.
// Reset clears control state, the entry count and the byte total and loads the register
// defaults; the entry memory is not cleared and needs no pass.
// A result sits in the output register until taken; the next beat is accepted meanwhile,
// and its result waits in the datapath staging registers until that register is free.

module byte_budget_fifo_cache_core
    import bbfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bbfc_req_if.sink              i_req,
    bbfc_rsp_if.source            o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    bbfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bbfc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_req.func),
        .i_clip_key    (i_req.clip_key),
        .i_path_key    (i_req.path_key),
        .i_buffer_tag  (i_req.buffer_tag),
        .i_byte_count  (i_req.byte_count),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_hit         (o_rsp.hit),
        .o_tag_out     (o_rsp.tag_out),
        .o_evicted     (o_rsp.evicted),
        .o_entry_count (o_rsp.entry_count),
        .o_total_bytes (o_rsp.total_bytes)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bbfc_ctrl.sv =====
`default_nettype none

module bbfc_ctrl
    import bbfc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_PUB
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    t_cmd   cmd;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.func) inside
                    FN_INSERT: begin
                        n_state = i_stat.reject ? ST_PUB : ST_SCAN;
                    end
                    FN_LOOKUP, FN_DROP: begin
                        n_state = ST_SCAN;
                    end
                    FN_CLEAR: begin
                        cmd.clear = 1'b1;
                        n_state   = ST_PUB;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    cmd.scan_end = 1'b1;
                    n_state = (i_stat.func == FN_INSERT) ? ST_EVICT_RD : ST_PUB;
                end
            end
            ST_EVICT_RD: begin
                if (i_stat.evict_need) begin
                    cmd.evict_rd = 1'b1;
                    n_state      = ST_EVICT_CHK;
                end else begin
                    cmd.append = 1'b1;
                    n_state    = ST_PUB;
                end
            end
            ST_EVICT_CHK: begin
                cmd.evict_chk = 1'b1;
                n_state       = ST_EVICT_RD;
            end
            ST_PUB: begin
                // The result register is free or being emptied in this cycle.
                if (!r_out_vld || i_out_ready) begin
                    cmd.publish = 1'b1;
                    n_out_vld   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

// ===== rtl/core/bbfc_dp.sv =====
`default_nettype none

module bbfc_dp
    import bbfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [KEY_W-1:0]      i_clip_key,
    input  logic [KEY_W-1:0]      i_path_key,
    input  logic [OTAG_W-1:0]     i_buffer_tag,
    input  logic [BYTES_W-1:0]    i_byte_count,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_hit,
    output logic [OTAG_W-1:0]     o_tag_out,
    output logic [EVC_W-1:0]      o_evicted,
    output logic [EVC_W-1:0]      o_entry_count,
    output logic [TOTO_W-1:0]     o_total_bytes
);

    // Entry memory, used as a ring: r_head is the oldest entry.
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;
    logic             mem_re, mem_we;
    logic [IDX_W-1:0] mem_raddr, mem_waddr;
    t_entry           mem_wdata;

    // Configuration and table state.
    logic [LIM_W-1:0]   r_limit, n_limit;
    logic [BYTES_W-1:0] r_budget, n_budget;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TOT_W-1:0]   r_total, n_total;

    // Captured operation.
    t_func               r_func, n_func;
    logic [KEY_W-1:0]    r_ckey, n_ckey;
    logic [KEY_W-1:0]    r_pkey, n_pkey;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;

    // Scan and eviction working registers.
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_wr, n_wr;
    logic              r_dv, n_dv;
    logic [TOT_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_removed, n_removed;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W:0]    r_n, n_n;
    logic [TOT_W-1:0]  r_rem, n_rem;
    logic [IDX_W-1:0]  r_app, n_app;

    // Result staging and output registers.
    logic                r_hit, n_hit;
    logic [TAG_BITS-1:0] r_tag_res, n_tag_res;
    logic [CNT_W-1:0]    r_evict, n_evict;
    logic                r_o_hit, n_o_hit;
    logic [OTAG_W-1:0]   r_o_tag, n_o_tag;
    logic [EVC_W-1:0]    r_o_evicted, n_o_evicted;
    logic [EVC_W-1:0]    r_o_count, n_o_count;
    logic [TOTO_W-1:0]   r_o_total, n_o_total;

    logic           match;
    logic [CNT_W:0] live;

    assign match = (r_rdata.clip_key == r_ckey) &&
                   ((r_func == FN_DROP) || (r_rdata.path_key == r_pkey));
    // Entries that would remain if the oldest r_k were evicted.
    assign live  = r_n - (CNT_W + 1)'(r_k);

    always_comb begin
        o_stat.func       = r_func;
        o_stat.reject     = (r_bytes == '0) || (r_limit == '0) || (r_bytes > r_budget);
        o_stat.scan_done  = (r_rd == r_count) && !r_dv;
        o_stat.evict_need = (CMP_W'(live) > CMP_W'(r_limit)) ||
                            (CMP_W'(live) > CMP_W'(TABLE_DEPTH)) ||
                            (r_rem > TOT_W'(r_budget));
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = phys_addr(r_head, r_rd);
        if (i_cmd.scan && (r_rd < r_count)) begin
            mem_re = 1'b1;
        end
        if (i_cmd.evict_rd) begin
            mem_re    = 1'b1;
            mem_raddr = phys_addr(r_head, r_k);
        end
        // Compaction moves a kept entry down to the write position.
        mem_we    = i_cmd.scan && r_dv && !match && (r_func != FN_LOOKUP);
        mem_waddr = phys_addr(r_head, r_wr);
        mem_wdata = r_rdata;
        if (i_cmd.append) begin
            mem_we    = 1'b1;
            mem_waddr = r_app;
            mem_wdata = '{clip_key: r_ckey, path_key: r_pkey, tag: r_tag, size: r_bytes};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_limit     = r_limit;
        n_budget    = r_budget;
        n_head      = r_head;
        n_count     = r_count;
        n_total     = r_total;
        n_func      = r_func;
        n_ckey      = r_ckey;
        n_pkey      = r_pkey;
        n_tag       = r_tag;
        n_bytes     = r_bytes;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_dv        = r_dv;
        n_sum       = r_sum;
        n_removed   = r_removed;
        n_k         = r_k;
        n_n         = r_n;
        n_rem       = r_rem;
        n_app       = r_app;
        n_hit       = r_hit;
        n_tag_res   = r_tag_res;
        n_evict     = r_evict;
        n_o_hit     = r_o_hit;
        n_o_tag     = r_o_tag;
        n_o_evicted = r_o_evicted;
        n_o_count   = r_o_count;
        n_o_total   = r_o_total;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ENTRY_LIMIT: n_limit  = i_cfg_data[LIM_W-1:0];
                REG_BYTE_BUDGET: n_budget = i_cfg_data[BYTES_W-1:0];
                default: ;
            endcase
        end

        if (i_cmd.load) begin
            n_func    = t_func'(i_func);
            n_ckey    = i_clip_key;
            n_pkey    = i_path_key;
            n_tag     = tag_from_in(i_buffer_tag);
            n_bytes   = i_byte_count;
            n_rd      = '0;
            n_wr      = '0;
            n_dv      = 1'b0;
            n_sum     = '0;
            n_removed = '0;
            n_hit     = 1'b0;
            n_tag_res = '0;
            n_evict   = '0;
        end

        if (i_cmd.scan) begin
            n_dv = (r_rd < r_count);
            if (r_rd < r_count) begin
                n_rd = r_rd + 1'b1;
            end
            if (r_dv) begin
                if (r_func == FN_LOOKUP) begin
                    if (match && !r_hit) begin
                        n_hit     = 1'b1;
                        n_tag_res = r_rdata.tag;
                    end
                end else if (match) begin
                    n_removed = r_removed + 1'b1;
                end else begin
                    n_wr  = r_wr + 1'b1;
                    n_sum = r_sum + TOT_W'(r_rdata.size);
                end
            end
        end

        if (i_cmd.scan_end) begin
            if (r_func == FN_INSERT) begin
                n_n     = (CNT_W + 1)'(r_wr) + 1'b1;
                n_k     = '0;
                n_rem   = r_sum + TOT_W'(r_bytes);
                n_app   = phys_addr(r_head, r_wr);
                n_evict = r_removed;
            end else if (r_func == FN_DROP) begin
                n_count = r_wr;
                n_total = r_sum;
                n_evict = r_removed;
            end
        end

        if (i_cmd.evict_chk) begin
            n_rem = r_rem - TOT_W'(r_rdata.size);
            n_k   = r_k + 1'b1;
        end

        if (i_cmd.append) begin
            n_head    = phys_addr(r_head, r_k);
            n_count   = live[CNT_W-1:0];
            n_total   = r_rem;
            n_evict   = r_evict + r_k;
            n_hit     = 1'b1;
            n_tag_res = r_tag;
        end

        if (i_cmd.clear) begin
            n_evict = r_count;
            n_count = '0;
            n_total = '0;
        end

        if (i_cmd.publish) begin
            n_o_hit     = r_hit;
            n_o_tag     = tag_to_out(r_tag_res);
            n_o_evicted = sat_cnt(r_evict);
            n_o_count   = sat_cnt(r_count);
            n_o_total   = sat_total(r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIM_W'(LIMIT_RESET);
            r_budget <= '1;
            r_head   <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_dv     <= 1'b0;
        end else begin
            r_limit  <= n_limit;
            r_budget <= n_budget;
            r_head   <= n_head;
            r_count  <= n_count;
            r_total  <= n_total;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_dv     <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_ckey      <= n_ckey;
        r_pkey      <= n_pkey;
        r_tag       <= n_tag;
        r_bytes     <= n_bytes;
        r_sum       <= n_sum;
        r_removed   <= n_removed;
        r_k         <= n_k;
        r_n         <= n_n;
        r_rem       <= n_rem;
        r_app       <= n_app;
        r_hit       <= n_hit;
        r_tag_res   <= n_tag_res;
        r_evict     <= n_evict;
        r_o_hit     <= n_o_hit;
        r_o_tag     <= n_o_tag;
        r_o_evicted <= n_o_evicted;
        r_o_count   <= n_o_count;
        r_o_total   <= n_o_total;
    end

    assign o_hit         = r_o_hit;
    assign o_tag_out     = r_o_tag;
    assign o_evicted     = r_o_evicted;
    assign o_entry_count = r_o_count;
    assign o_total_bytes = r_o_total;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_rd)
        else $error("compaction write position passed the read position");

    // The new entry always fits on its own, so eviction stops before reaching it.
    a_evict_old_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict_rd |-> ((CNT_W + 1)'(r_k) + 1'b1 < r_n))
        else $error("eviction reached the entry being inserted");

    a_append_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> (r_count != '0) && r_hit)
        else $error("accepted insert left the table empty");

endmodule

`default_nettype wire

// ===== dv/byte_budget_fifo_cache_core_tb.sv =====
`timescale 1ns / 100ps

module byte_budget_fifo_cache_core_tb;
    import bbfc_pkg::*;

    localparam int                STALL_LIMIT = 3000;
    localparam int                RAND_ITEMS  = 85;
    localparam int                PHASES      = 12;
    localparam int                HOLD_CYCLES = 300;
    localparam logic [TOTO_W-1:0] TOTAL_SAT   = '1;

    typedef struct packed {
        t_func              func;
        logic [KEY_W-1:0]   clip_key;
        logic [KEY_W-1:0]   path_key;
        logic [OTAG_W-1:0]  buffer_tag;
        logic [BYTES_W-1:0] byte_count;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [OTAG_W-1:0]  tag_out;
        logic [EVC_W-1:0]   evicted;
        logic [EVC_W-1:0]   entry_count;
        logic [TOTO_W-1:0]  total_bytes;
    } t_rsp;

    typedef struct {
        t_req rq;
        bit   typed;
        t_rsp want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bbfc_req_if req_ch ();
    bbfc_rsp_if rsp_ch ();

    byte_budget_fifo_cache_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Shadow copy of the cache table, oldest entry at slot 0.
    logic [KEY_W-1:0]    m_clip [TABLE_DEPTH];
    logic [KEY_W-1:0]    m_path [TABLE_DEPTH];
    logic [OTAG_W-1:0]   m_tag  [TABLE_DEPTH];
    logic [BYTES_W-1:0]  m_size [TABLE_DEPTH];
    int                  m_count;
    logic [LIM_W-1:0]    m_limit;
    logic [BYTES_W-1:0]  m_budget;

    t_rsp                pending_rsp [$];
    logic [KEY_W-1:0]    clip_pool [4];
    logic [KEY_W-1:0]    path_pool [4];
    int                  errors;
    bit                  no_gaps;
    bit                  hold_rsp;
    t_dir_row            dir_table [20];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [TOTO_W-1:0] held_bytes();
        logic [TOTO_W:0] sum;
        sum = '0;
        for (int i = 0; i < m_count; i++) begin
            sum += m_size[i];
            if (sum > (TOTO_W + 1)'(TOTAL_SAT)) begin
                sum = (TOTO_W + 1)'(TOTAL_SAT);
            end
        end
        return sum[TOTO_W-1:0];
    endfunction

    function automatic void move_entry(input int dst, input int src);
        m_clip[dst] = m_clip[src];
        m_path[dst] = m_path[src];
        m_tag[dst]  = m_tag[src];
        m_size[dst] = m_size[src];
    endfunction

    // Compacts the table, removing entries that match the keys; returns the count removed.
    function automatic int purge_keys(input logic [KEY_W-1:0] ck, input logic [KEY_W-1:0] pk,
                                      input bit by_path);
        int w;
        int removed;
        w       = 0;
        removed = 0;
        for (int r = 0; r < m_count; r++) begin
            if (m_clip[r] == ck && (!by_path || m_path[r] == pk)) begin
                removed++;
            end else begin
                move_entry(w, r);
                w++;
            end
        end
        m_count = w;
        return removed;
    endfunction

    function automatic void shift_out_oldest();
        for (int i = 1; i < m_count; i++) begin
            move_entry(i - 1, i);
        end
        if (m_count > 0) begin
            m_count--;
        end
    endfunction

    function automatic t_rsp cache_predict(input t_req rq);
        t_rsp res;
        int   ev;
        int   eff_limit;
        res = '0;
        ev  = 0;
        case (rq.func)
            FN_INSERT: begin
                if (rq.byte_count != 0 && m_limit != 0 && rq.byte_count <= m_budget) begin
                    eff_limit = (m_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(m_limit);
                    ev += purge_keys(rq.clip_key, rq.path_key, 1'b1);
                    if (m_count >= TABLE_DEPTH) begin
                        shift_out_oldest();
                        ev++;
                    end
                    m_clip[m_count] = rq.clip_key;
                    m_path[m_count] = rq.path_key;
                    m_tag[m_count]  = rq.buffer_tag;
                    m_size[m_count] = rq.byte_count;
                    m_count++;
                    while (m_count > 0 && (m_count > eff_limit ||
                                           held_bytes() > TOTO_W'(m_budget))) begin
                        shift_out_oldest();
                        ev++;
                    end
                    if (m_count > 0) begin
                        res.hit     = 1'b1;
                        res.tag_out = m_tag[m_count-1];
                    end
                end
            end
            FN_LOOKUP: begin
                for (int i = 0; i < m_count; i++) begin
                    if (!res.hit && m_clip[i] == rq.clip_key && m_path[i] == rq.path_key) begin
                        res.hit     = 1'b1;
                        res.tag_out = m_tag[i];
                    end
                end
            end
            FN_DROP: begin
                ev = purge_keys(rq.clip_key, '0, 1'b0);
            end
            default: begin
                ev      = m_count;
                m_count = 0;
            end
        endcase
        res.evicted     = (ev > 31) ? 5'd31 : EVC_W'(ev);
        res.entry_count = (m_count > 31) ? 5'd31 : EVC_W'(m_count);
        res.total_bytes = held_bytes();
        return res;
    endfunction

    // Mostly short gaps, now and then a long one, none at all in gap-free phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic t_req next_request();
        t_req               rq;
        int                 r;
        logic [BYTES_W-1:0] cap;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            rq.func = FN_INSERT;
        end else if (r < 85) begin
            rq.func = FN_LOOKUP;
        end else if (r < 96) begin
            rq.func = FN_DROP;
        end else begin
            rq.func = FN_CLEAR;
        end
        // Keys come mostly from small pools so that lookups, dedupes and drops find entries.
        rq.clip_key   = ($urandom_range(0, 99) < 85) ? clip_pool[$urandom_range(0, 3)] : $urandom;
        rq.path_key   = ($urandom_range(0, 99) < 85) ? path_pool[$urandom_range(0, 3)] : $urandom;
        rq.buffer_tag = OTAG_W'($urandom);
        cap = m_budget / 6;
        if (cap == 0) begin
            cap = 1;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            rq.byte_count = '0;
        end else if (r < 6) begin
            rq.byte_count = '1;
        end else if (r < 10) begin
            rq.byte_count = m_budget;
        end else if (r < 13) begin
            rq.byte_count = m_budget + 1;
        end else if (r < 45) begin
            rq.byte_count = $urandom_range(1, 255);
        end else begin
            rq.byte_count = $urandom_range(1, cap);
        end
        return rq;
    endfunction

    task automatic send_item(input t_req rq, input int gap, input bit typed, input t_rsp want);
        t_rsp model_rsp;
        req_ch.valid      <= 1'b1;
        req_ch.func       <= rq.func;
        req_ch.clip_key   <= rq.clip_key;
        req_ch.path_key   <= rq.path_key;
        req_ch.buffer_tag <= rq.buffer_tag;
        req_ch.byte_count <= rq.byte_count;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        model_rsp   = cache_predict(rq);
        pending_rsp = {pending_rsp, (typed ? want : model_rsp)};
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_limits(input logic [LIM_W-1:0] lim, input logic [BYTES_W-1:0] bud);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ENTRY_LIMIT;
        i_cfg_data <= CFG_DATA_W'(lim);
        @(posedge i_clk);
        m_limit     = lim;
        i_cfg_idx  <= REG_BYTE_BUDGET;
        i_cfg_data <= bud;
        @(posedge i_clk);
        m_budget    = bud;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [TOTO_W-1:0] want,
                               input logic [TOTO_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side: checks each beat against the oldest expectation and stalls at random.
    initial begin
        int   stall_left;
        t_rsp got;
        t_rsp want;
        stall_left    = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
                got = {rsp_ch.hit, rsp_ch.tag_out, rsp_ch.evicted, rsp_ch.entry_count,
                       rsp_ch.total_bytes};
                if (pending_rsp.size() == 0) begin
                    $display("%0t: result beat with nothing pending, got %0h", $time, got);
                    errors++;
                end else begin
                    want = pending_rsp.pop_front();
                    check_field("hit", TOTO_W'(want.hit), TOTO_W'(got.hit));
                    check_field("tag_out", TOTO_W'(want.tag_out), TOTO_W'(got.tag_out));
                    check_field("evicted", TOTO_W'(want.evicted), TOTO_W'(got.evicted));
                    check_field("entry_count", TOTO_W'(want.entry_count),
                                TOTO_W'(got.entry_count));
                    check_field("total_bytes", want.total_bytes, got.total_bytes);
                end
            end
            if (hold_rsp) begin
                hold_rsp   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                stall_left    = pick_gap();
                rsp_ch.ready <= (stall_left == 0);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("byte_budget_fifo_cache_core: mismatch");
        $finish;
    end

    initial begin
        logic [LIM_W-1:0]   phase_lim [8];
        logic [BYTES_W-1:0] phase_bud [8];
        logic [LIM_W-1:0]   lim;
        logic [BYTES_W-1:0] bud;
        t_req               rq;
        int                 gap;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= '0;
        req_ch.clip_key   <= '0;
        req_ch.path_key   <= '0;
        req_ch.buffer_tag <= '0;
        req_ch.byte_count <= '0;
        errors   = 0;
        no_gaps  = 1'b0;
        hold_rsp = 1'b0;
        m_count  = 0;
        m_limit  = LIM_W'(LIMIT_RESET);
        m_budget = '1;

        // Directed rows run on the reset limits and start from an empty table.
        dir_table = '{
            '{'{FN_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0}, 1'b1,
              '{1'b0, 16'h0, 5'd0, 5'd0, 36'h0}},
            '{'{FN_CLEAR, 32'h0, 32'h0, 16'h0, 32'h0}, 1'b1,
              '{1'b0, 16'h0, 5'd0, 5'd0, 36'h0}},
            '{'{FN_DROP, 32'hFFFF_FFFF, 32'h0, 16'h0, 32'h0}, 1'b1,
              '{1'b0, 16'h0, 5'd0, 5'd0, 36'h0}},
            // A zero-sized insert is refused.
            '{'{FN_INSERT, 32'h1, 32'h2, 16'hFFFF, 32'h0}, 1'b1,
              '{1'b0, 16'h0, 5'd0, 5'd0, 36'h0}},
            '{'{FN_INSERT, 32'h0, 32'h0, 16'h0, 32'hFFFF_FFFF}, 1'b1,
              '{1'b1, 16'h0, 5'd0, 5'd1, 36'hFFFF_FFFF}},
            // One more byte overflows the budget, so the full-budget entry goes.
            '{'{FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h1}, 1'b1,
              '{1'b1, 16'hFFFF, 5'd1, 5'd1, 36'h1}},
            '{'{FN_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 32'h0}, 1'b1,
              '{1'b1, 16'hFFFF, 5'd0, 5'd1, 36'h1}},
            '{'{FN_LOOKUP, 32'h0, 32'h0, 16'h0, 32'h0}, 1'b1,
              '{1'b0, 16'h0, 5'd0, 5'd1, 36'h1}},
            // Same two keys again: the old entry is replaced.
            '{'{FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234, 32'd100}, 1'b1,
              '{1'b1, 16'h1234, 5'd1, 5'd1, 36'd100}},
            '{'{FN_INSERT, 32'h5, 32'h6, 16'hA5A5, 32'd200}, 1'b0, '0},
            '{'{FN_INSERT, 32'h5, 32'h7, 16'h5A5A, 32'd300}, 1'b0, '0},
            '{'{FN_INSERT, 32'h8, 32'h6, 16'h00FF, 32'd400}, 1'b0, '0},
            '{'{FN_LOOKUP, 32'h5, 32'h7, 16'h0, 32'h0}, 1'b0, '0},
            '{'{FN_DROP, 32'h5, 32'h0, 16'h0, 32'h0}, 1'b0, '0},
            '{'{FN_LOOKUP, 32'h5, 32'h6, 16'h0, 32'h0}, 1'b0, '0},
            '{'{FN_CLEAR, 32'h0, 32'h0, 16'h0, 32'h0}, 1'b0, '0},
            '{'{FN_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 32'h8000_0000}, 1'b0, '0},
            '{'{FN_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 32'h7FFF_FFFF}, 1'b0, '0},
            '{'{FN_INSERT, 32'h1, 32'h1, 16'hFF00, 32'h1}, 1'b0, '0},
            '{'{FN_CLEAR, 32'h0, 32'h0, 16'h0, 32'h0}, 1'b0, '0}
        };

        // Fixed settings first (limit above depth, zero limit, zero budget), then random ones.
        phase_lim = '{5'd16, 5'd31, 5'd2, 5'd0, 5'd16, 5'd1, 5'd8, 5'd20};
        phase_bud = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'h0, 32'd1000, 32'd5000, 32'd100000};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[k]) begin
            gap = (k == $size(dir_table) - 1) ? 1 + pick_gap() : pick_gap();
            send_item(dir_table[k].rq, gap, dir_table[k].typed, dir_table[k].want);
        end
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                lim = phase_lim[p];
                bud = phase_bud[p];
            end else begin
                lim = $urandom_range(1, TABLE_DEPTH);
                bud = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(64, 20000);
            end
            // The table may still be over the new limits; the next accepted insert trims it.
            write_limits(lim, bud);
            no_gaps = (p % 4 == 1);
            for (int i = 0; i < 4; i++) begin
                clip_pool[i] = $urandom;
                path_pool[i] = $urandom;
            end
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (p == 0 && n == 40) begin
                    hold_rsp = 1'b1;
                end
                send_item(next_request(), pick_gap(), 1'b0, '0);
            end
            // Fill with fresh small entries, up to the limits of the phase.
            for (int n = 0; n < TABLE_DEPTH; n++) begin
                rq = '{FN_INSERT, $urandom, $urandom, OTAG_W'($urandom),
                       BYTES_W'($urandom_range(1, 64))};
                gap = (n == TABLE_DEPTH - 1) ? 1 + pick_gap() : pick_gap();
                send_item(rq, gap, 1'b0, '0);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("byte_budget_fifo_cache_core: match");
        end else begin
            $display("byte_budget_fifo_cache_core: mismatch");
        end
        $finish;
    end

endmodule
